[hw/rtl/frre_pkg.sv]
// Package: shared types and constants of the frame routing rule engine.
package frre_pkg;

  localparam int RuleSlotsDef   = 16;
  localparam int MapsPerRuleDef = 8;
  localparam int MapWordW       = 40;
  localparam logic [31:0] PassthroughId = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FUNC_PROCESS   = 3'd0,
    FUNC_WR_MATCH  = 3'd1,
    FUNC_WR_ACTION = 3'd2,
    FUNC_WR_MAP    = 3'd3,
    FUNC_CLEAR     = 3'd4
  } func_t;

  // Frame travelling down the cell chain
  typedef struct packed {
    logic        vld;
    logic [1:0]  bus;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [7:0]  flags;
    logic [63:0] data;
    logic [31:0] ts;
  } frame_t;

  // Write command travelling down the cell chain
  typedef struct packed {
    logic        vld;
    logic [2:0]  func;
    logic [5:0]  index;
    logic [3:0]  map_slot;
    logic [1:0]  bus;
    logic        enable;
    logic [31:0] id_value;
    logic [31:0] id_mask;
    logic [3:0]  dlc;
    logic [3:0]  map_count;
    logic [39:0] map_word;
  } wcmd_t;

  // Routing result handed from a cell to the collector
  typedef struct packed {
    logic        hit;
    logic [1:0]  bus;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [7:0]  flags;
    logic [63:0] data;
    logic [31:0] ts;
  } hit_t;

  // One byte mapping: mask, signed shift, wrapping offset
  function automatic logic [7:0] map_byte(input logic [7:0] src, input logic [39:0] w);
    logic [7:0] msk;
    logic [7:0] sh;
    logic [7:0] v;
    logic [7:0] r;
    msk = w[23:16];
    sh  = w[31:24];
    v   = src & msk;
    r   = 8'd0 - sh;
    if (sh != 8'd0 && !sh[7]) begin
      v = (sh >= 8'd8) ? 8'd0 : (v << sh[2:0]);
    end else if (sh[7]) begin
      v = (r >= 8'd8) ? 8'd0 : (v >> r[2:0]);
    end
    return v + w[39:32];
  endfunction

endpackage

[hw/rtl/frame_routing_rule_engine.sv]
// Top level: input stage, chain of rule cells, result collector and output register.
//  channel | dir | tdata / tuser
//  in_*    | in  | command or frame, see port comments
//  out_*   | out | routed frame or drop notice, tlast on final result
// One transaction walks the chain cell by cell, then each matching cell steps through its
// mappings; results then drain one a cycle unless the output stalls.
// Reset clears rules, counters and control; in_tready stays low while a transaction
// is in flight. Output stalls hold the block.
module frame_routing_rule_engine
  import frre_pkg::*;
#(
  parameter int RULE_SLOTS    = RuleSlotsDef,
  parameter int MAPS_PER_RULE = MapsPerRuleDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func, index, map_slot, bus, enable, id_value, id_mask, dlc, flags, map_count,
  // payload, timestamp
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_bus, out_id, out_dlc, out_flags, out_data, out_time, rule_number,
  // routed_total, dropped_total
  output logic [215:0] out_tdata,
  output logic         out_tlast,
  // kind
  output logic         out_tuser
);
  localparam int RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int TW = $clog2(RULE_SLOTS + MAPS_PER_RULE + 8);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} st_t;
  st_t st_r;

  frame_t frm_c [RULE_SLOTS+1];
  wcmd_t  cmd_c [RULE_SLOTS+1];
  hit_t   hit_c [RULE_SLOTS];
  logic   busy_c [RULE_SLOTS];

  hit_t   res_r [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] pend_r;
  logic [TW-1:0] cnt_r;
  logic [31:0] routed_r, dropped_r, ts_r;
  logic        isfrm_r, anyhit_r;

  logic [2:0]  f;
  logic        anybusy;
  logic        anyhit_c;
  logic [RW-1:0] sel;
  logic        more;

  assign f = in_tdata[2:0];
  assign in_tready = (st_r == S_IDLE);

  always_comb begin
    frm_c[0]       = '0;
    frm_c[0].vld   = in_tvalid && in_tready && f == FUNC_PROCESS;
    frm_c[0].bus   = in_tdata[11:10];
    frm_c[0].id    = in_tdata[44:13];
    frm_c[0].dlc   = in_tdata[80:77];
    frm_c[0].flags = in_tdata[88:81];
    frm_c[0].data  = in_tdata[156:93];
    frm_c[0].ts    = in_tdata[188:157];
    cmd_c[0]           = '0;
    cmd_c[0].vld       = in_tvalid && in_tready && (f == FUNC_WR_MATCH ||
                         f == FUNC_WR_ACTION || f == FUNC_WR_MAP || f == FUNC_CLEAR);
    cmd_c[0].func      = f;
    cmd_c[0].index     = {2'b00, in_tdata[6:3]};
    cmd_c[0].map_slot  = {1'b0, in_tdata[9:7]};
    cmd_c[0].bus       = in_tdata[11:10];
    cmd_c[0].enable    = in_tdata[12];
    cmd_c[0].id_value  = in_tdata[44:13];
    cmd_c[0].id_mask   = in_tdata[76:45];
    cmd_c[0].dlc       = in_tdata[80:77];
    cmd_c[0].map_count = in_tdata[92:89];
    cmd_c[0].map_word  = in_tdata[132:93];
  end

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    frre_cell #(.SLOT(g), .MAPS_PER_RULE(MAPS_PER_RULE)) u_cell (
      .clk, .rst_n,
      .frm_i(frm_c[g]), .cmd_i(cmd_c[g]),
      .frm_o(frm_c[g+1]), .cmd_o(cmd_c[g+1]),
      .hit_o(hit_c[g]), .busy_o(busy_c[g])
    );
  end

  always_comb begin
    anybusy = 1'b0;
    anyhit_c = 1'b0;
    sel = '0;
    more = 1'b0;
    for (int i = 0; i < RULE_SLOTS; i++) anybusy |= busy_c[i];
    for (int i = 0; i < RULE_SLOTS; i++) anyhit_c |= hit_c[i].hit;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) if (pend_r[i]) sel = RW'(i);
    for (int i = 0; i < RULE_SLOTS; i++) if (pend_r[i] && RW'(i) != sel) more = 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RULE_SLOTS; i++) if (hit_c[i].hit) res_r[i] <= hit_c[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pend_r <= '0; cnt_r <= '0; routed_r <= '0; dropped_r <= '0;
      out_tvalid <= 1'b0; out_tdata <= '0; out_tlast <= 1'b0; out_tuser <= 1'b0;
      isfrm_r <= 1'b0; anyhit_r <= 1'b0; ts_r <= '0;
    end else begin
      for (int i = 0; i < RULE_SLOTS; i++) if (hit_c[i].hit) pend_r[i] <= 1'b1;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            st_r <= S_RUN; cnt_r <= '0; anyhit_r <= 1'b0;
            isfrm_r <= (f == FUNC_PROCESS);
            ts_r <= in_tdata[188:157];
          end
        end
        S_RUN: begin
          if (anyhit_c) anyhit_r <= 1'b1;
          if (cnt_r != TW'(RULE_SLOTS + 1)) cnt_r <= cnt_r + 1'b1;
          else if (!anybusy) begin
            // last cell may report its hit in this very cycle
            st_r <= isfrm_r ? S_DRAIN : S_IDLE;
            if (isfrm_r && (anyhit_r || anyhit_c)) routed_r <= routed_r + 32'd1;
            if (isfrm_r && !(anyhit_r || anyhit_c)) dropped_r <= dropped_r + 32'd1;
          end
        end
        S_DRAIN: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            if (!anyhit_r) begin
              out_tdata <= {6'd0, dropped_r, routed_r, 4'd0, ts_r, 110'd0};
              out_tuser <= 1'b1; out_tlast <= 1'b1;
              st_r <= S_OUT;
            end else begin
              out_tdata <= {6'd0, dropped_r, routed_r, 4'(sel), res_r[sel].ts,
                            res_r[sel].data, res_r[sel].flags, res_r[sel].dlc,
                            res_r[sel].id, res_r[sel].bus};
              out_tuser <= 1'b0; out_tlast <= !more;
              pend_r[sel] <= 1'b0;
              if (!more) st_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/frre_cell.sv]
// One rule slot: holds its rule, matches the passing frame, builds data mapping by mapping.
module frre_cell
  import frre_pkg::*;
#(
  parameter int SLOT          = 0,
  parameter int MAPS_PER_RULE = MapsPerRuleDef
) (
  input  logic   clk,
  input  logic   rst_n,
  input  frame_t frm_i,
  input  wcmd_t  cmd_i,
  output frame_t frm_o,
  output wcmd_t  cmd_o,
  output hit_t   hit_o,
  output logic   busy_o
);
  localparam int MW = (MAPS_PER_RULE > 1) ? $clog2(MAPS_PER_RULE) : 1;
  localparam int CW = $clog2(MAPS_PER_RULE + 1);

  logic        en_r, en_nxt;
  logic [1:0]  sbus_r;
  logic [31:0] sid_r, smask_r;
  logic [1:0]  dbus_r;
  logic [31:0] did_r;
  logic [3:0]  ddlc_r;
  logic [3:0]  nmap_r;
  logic [MapWordW-1:0] map_r [MAPS_PER_RULE];

  // mapping sequencer
  logic        act_r;
  logic [CW-1:0] step_r, n_r;
  frame_t      frm_r;
  logic [63:0] acc_r;

  logic        wr_here;
  logic        match;
  logic [CW-1:0] n_eff;
  logic [MW-1:0] sidx;
  logic [MapWordW-1:0] w;
  logic [7:0]  mb;
  logic [63:0] acc_nxt;

  assign wr_here = cmd_i.vld && (cmd_i.index == 6'(SLOT));
  assign match   = frm_i.vld && en_r && (sbus_r == frm_i.bus)
                   && ((frm_i.id & smask_r) == (sid_r & smask_r));
  assign n_eff   = (32'(nmap_r) > MAPS_PER_RULE) ? CW'(MAPS_PER_RULE) : CW'(nmap_r);
  assign sidx    = MW'(step_r);
  assign w       = map_r[sidx];
  assign mb      = map_byte(frm_r.data[8*w[2:0] +: 8], w);
  always_comb begin
    acc_nxt = acc_r;
    if (w[7:3] == 5'd0 && w[15:11] == 5'd0) acc_nxt[8*w[10:8] +: 8] = acc_r[8*w[10:8] +: 8] | mb;
  end
  assign en_nxt = (cmd_i.func == FUNC_WR_MATCH) ? cmd_i.enable : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; sbus_r <= '0; sid_r <= '0; smask_r <= '0;
      dbus_r <= '0; did_r <= '0; ddlc_r <= '0; nmap_r <= '0;
      for (int i = 0; i < MAPS_PER_RULE; i++) map_r[i] <= '0;
      act_r <= 1'b0; frm_o <= '0; cmd_o <= '0; hit_o <= '0;
      step_r <= '0; n_r <= '0;
    end else begin
      frm_o <= frm_i;
      cmd_o <= cmd_i;
      hit_o.hit <= 1'b0;
      if (cmd_i.vld && cmd_i.func == FUNC_CLEAR) begin
        en_r <= 1'b0; sbus_r <= '0; sid_r <= '0; smask_r <= '0;
        dbus_r <= '0; did_r <= '0; ddlc_r <= '0; nmap_r <= '0;
        for (int i = 0; i < MAPS_PER_RULE; i++) map_r[i] <= '0;
      end else if (wr_here && cmd_i.func == FUNC_WR_MATCH) begin
        en_r <= en_nxt; sbus_r <= cmd_i.bus; sid_r <= cmd_i.id_value;
        smask_r <= cmd_i.id_mask;
      end else if (wr_here && cmd_i.func == FUNC_WR_ACTION) begin
        dbus_r <= cmd_i.bus; did_r <= cmd_i.id_value; ddlc_r <= cmd_i.dlc;
        nmap_r <= cmd_i.map_count;
      end else if (wr_here && cmd_i.func == FUNC_WR_MAP
                   && 32'(cmd_i.map_slot) < MAPS_PER_RULE) begin
        map_r[MW'(cmd_i.map_slot)] <= cmd_i.map_word;
      end
      if (match) begin
        act_r  <= 1'b1;
        step_r <= '0;
        n_r    <= n_eff;
      end else if (act_r) begin
        if (step_r == n_r) begin
          act_r <= 1'b0;
          hit_o.hit   <= 1'b1;
          hit_o.bus   <= dbus_r;
          hit_o.id    <= (did_r == PassthroughId) ? frm_r.id : did_r;
          hit_o.dlc   <= (ddlc_r != 4'd0) ? ddlc_r : frm_r.dlc;
          hit_o.flags <= dbus_r[1] ? 8'd0 : frm_r.flags;
          hit_o.data  <= (n_r == '0) ? frm_r.data : acc_r;
          hit_o.ts    <= frm_r.ts;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      frm_r <= frm_i;
      acc_r <= '0;
    end else if (act_r && step_r != n_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign busy_o = act_r;
endmodule

[test/tb_top.sv]
// Testbench for the frame routing rule engine: stream driver, predictor and result checker.
module tb_top;
  import frre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int NMAP = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLDOFF_START = 2500;
  localparam int HOLDOFF_LEN = 600;
  localparam logic [2:0] FUNC_SPARE = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  index;
    logic [2:0]  map_slot;
    logic [1:0]  bus;
    logic        enable;
    logic [31:0] id_value;
    logic [31:0] id_mask;
    logic [3:0]  dlc;
    logic [7:0]  flags;
    logic [3:0]  map_count;
    logic [63:0] payload;
    logic [31:0] timestamp;
    bit          drain_first;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  bus;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [7:0]  flags;
    logic [63:0] data;
    logic [31:0] ts;
    logic [3:0]  rule;
    logic        last;
    logic [31:0] routed;
    logic [31:0] dropped;
  } route_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [215:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  frame_routing_rule_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  // predictor state
  logic        rule_en[NSLOT];
  logic [1:0]  rule_sbus[NSLOT];
  logic [31:0] rule_sid[NSLOT];
  logic [31:0] rule_smask[NSLOT];
  logic [1:0]  act_dbus[NSLOT];
  logic [31:0] act_did[NSLOT];
  logic [3:0]  act_dlc[NSLOT];
  logic [3:0]  act_nmap[NSLOT];
  logic [39:0] map_word[NSLOT][NMAP];
  logic [31:0] routed_cnt;
  logic [31:0] dropped_cnt;

  cmd_t pending_cmds[$];
  route_res_t expected_routes[$];
  int errors = 0;
  int cyc = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;

  function automatic logic [191:0] pack_cmd(cmd_t c);
    return {3'd0, c.timestamp, c.payload, c.map_count, c.flags, c.dlc, c.id_mask,
            c.id_value, c.enable, c.bus, c.map_slot, c.index, c.func};
  endfunction

  function automatic void clear_rules();
    for (int s = 0; s < NSLOT; s++) begin
      rule_en[s] = 0; rule_sbus[s] = 0; rule_sid[s] = 0; rule_smask[s] = 0;
      act_dbus[s] = 0; act_did[s] = 0; act_dlc[s] = 0; act_nmap[s] = 0;
      for (int m = 0; m < NMAP; m++) map_word[s][m] = '0;
    end
  endfunction

  function automatic logic [7:0] remap_byte(logic [7:0] src, logic [39:0] w);
    logic [7:0] sh;
    logic [8:0] r;
    logic [7:0] v;
    sh = w[31:24];
    v = src & w[23:16];
    if (sh != 0 && sh < 128) begin
      v = (sh >= 8) ? 8'd0 : 8'((v << sh) & 8'hFF);
    end else if (sh >= 128) begin
      r = 9'd256 - {1'b0, sh};
      v = (r >= 8) ? 8'd0 : (v >> r);
    end
    return v + w[39:32];
  endfunction

  function automatic logic [63:0] rebuild_data(int s, logic [63:0] din);
    logic [63:0] acc;
    int n;
    int sb;
    int db;
    acc = '0;
    n = int'(act_nmap[s]);
    if (n == 0) return din;
    if (n > NMAP) n = NMAP;
    for (int i = 0; i < n; i++) begin
      sb = int'(map_word[s][i][7:0]);
      db = int'(map_word[s][i][15:8]);
      if (sb > 7 || db > 7) continue;
      acc |= 64'(remap_byte(din[sb*8 +: 8], map_word[s][i])) << (db * 8);
    end
    return acc;
  endfunction

  function automatic void route_frame(cmd_t c);
    route_res_t r;
    route_res_t hits[$];
    case (c.func)
      FUNC_WR_MATCH: begin
        rule_en[c.index] = c.enable; rule_sbus[c.index] = c.bus;
        rule_sid[c.index] = c.id_value; rule_smask[c.index] = c.id_mask;
      end
      FUNC_WR_ACTION: begin
        act_dbus[c.index] = c.bus; act_did[c.index] = c.id_value;
        act_dlc[c.index] = c.dlc; act_nmap[c.index] = c.map_count;
      end
      FUNC_WR_MAP: map_word[c.index][c.map_slot] = c.payload[39:0];
      FUNC_CLEAR: clear_rules();
      FUNC_PROCESS: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (!rule_en[s] || rule_sbus[s] != c.bus) continue;
          if ((c.id_value & rule_smask[s]) != (rule_sid[s] & rule_smask[s])) continue;
          r = '0;
          r.bus = act_dbus[s];
          r.id = (act_did[s] == PassthroughId) ? c.id_value : act_did[s];
          r.dlc = (act_dlc[s] != 0) ? act_dlc[s] : c.dlc;
          r.flags = (act_dbus[s] <= 1) ? c.flags : 8'd0;
          r.data = rebuild_data(s, c.payload);
          r.ts = c.timestamp;
          r.rule = 4'(s);
          hits.push_back(r);
        end
        if (hits.size() > 0) routed_cnt++;
        else begin
          dropped_cnt++;
          r = '0; r.kind = 1; r.ts = c.timestamp;
          hits.push_back(r);
        end
        hits[hits.size()-1].last = 1;
        foreach (hits[k]) begin
          hits[k].routed = routed_cnt;
          hits[k].dropped = dropped_cnt;
          expected_routes.push_back(hits[k]);
        end
      end
      default: ;
    endcase
  endfunction

  // driver: bursts with random gaps
  cmd_t cur_cmd;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) route_frame(cur_cmd);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain_first && expected_routes.size() > 0)) begin
          cur_cmd = pending_cmds.pop_front();
          in_tdata <= pack_cmd(cur_cmd);
          in_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise alternating free and choppy windows
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) out_tready <= 1'b0;
    else if (cyc >= HOLDOFF_START && cyc < HOLDOFF_START + HOLDOFF_LEN) out_tready <= 1'b0;
    else if (cyc[8]) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) < 6);
  end

  // monitor
  route_res_t got;
  route_res_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[1:0], out_tdata[33:2], out_tdata[37:34], out_tdata[45:38],
             out_tdata[109:46], out_tdata[141:110], out_tdata[145:142], out_tlast,
             out_tdata[177:146], out_tdata[209:178]};
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_routes.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result differs (kind bus id dlc flags data ts rule last routed dropped)",
                   $time);
          $display("  exp %h %h %h %h %h %h %h %h %h %h %h", want.kind, want.bus, want.id,
                   want.dlc, want.flags, want.data, want.ts, want.rule, want.last,
                   want.routed, want.dropped);
          $display("  act %h %h %h %h %h %h %h %h %h %h %h", got.kind, got.bus, got.id,
                   got.dlc, got.flags, got.data, got.ts, got.rule, got.last,
                   got.routed, got.dropped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("frame_routing_rule_engine: mismatch");
      $finish;
    end
  end

  // stimulus generation
  logic [1:0]  gen_bus[NSLOT];
  logic [31:0] gen_id[NSLOT];
  logic [31:0] gen_mask[NSLOT];

  function automatic cmd_t rand_cmd(logic [2:0] f);
    cmd_t c;
    c.func = f;
    c.index = 4'($urandom); c.map_slot = 3'($urandom); c.bus = 2'($urandom);
    c.enable = 1'($urandom);
    c.id_value = $urandom; c.id_mask = $urandom; c.dlc = 4'($urandom);
    c.flags = 8'($urandom);
    c.map_count = 4'($urandom); c.payload = {$urandom, $urandom}; c.timestamp = $urandom;
    c.drain_first = 0;
    return c;
  endfunction

  task automatic add_rule(int s, logic [1:0] b, logic [31:0] id, logic [31:0] m, logic en);
    cmd_t c;
    c = rand_cmd(FUNC_WR_MATCH);
    c.index = 4'(s); c.bus = b; c.id_value = id; c.id_mask = m; c.enable = en;
    gen_bus[s] = b; gen_id[s] = id; gen_mask[s] = m;
    pending_cmds.push_back(c);
  endtask

  task automatic add_action(int s, logic [1:0] b, logic [31:0] id, logic [3:0] d,
                            logic [3:0] n);
    cmd_t c;
    c = rand_cmd(FUNC_WR_ACTION);
    c.index = 4'(s); c.bus = b; c.id_value = id; c.dlc = d; c.map_count = n;
    pending_cmds.push_back(c);
  endtask

  task automatic add_map(int s, int m, logic [7:0] sb, logic [7:0] db, logic [7:0] msk,
                         logic [7:0] sh, logic [7:0] off);
    cmd_t c;
    c = rand_cmd(FUNC_WR_MAP);
    c.index = 4'(s); c.map_slot = 3'(m); c.payload[39:0] = {off, sh, msk, db, sb};
    pending_cmds.push_back(c);
  endtask

  task automatic add_frame(int s, bit aim);
    cmd_t c;
    c = rand_cmd(FUNC_PROCESS);
    if (aim) begin
      c.bus = gen_bus[s];
      c.id_value = (gen_id[s] & gen_mask[s]) | (c.id_value & ~gen_mask[s]);
    end
    pending_cmds.push_back(c);
  endtask

  cmd_t tmp;
  int s;
  int pick;
  initial begin
    clear_rules();
    routed_cnt = 0;
    dropped_cnt = 0;
    for (int k = 0; k < NSLOT; k++) begin
      gen_bus[k] = 0; gen_id[k] = 0; gen_mask[k] = 0;
    end

    // directed part
    add_frame(0, 0);                                   // empty table: drop
    add_rule(0, 2'd0, 32'h0000_0123, 32'hFFFF_FFFF, 1);
    add_action(0, 2'd1, PassthroughId, 4'd0, 4'd0);    // passthrough, whole copy
    add_rule(15, 2'd0, 32'h0000_0100, 32'hFFFF_FF00, 1);
    add_action(15, 2'd3, 32'hFFFF_FFFE, 4'd15, 4'd15); // LIN, dlc override, count above max
    add_map(15, 0, 8'd0, 8'd7, 8'hFF, 8'd3, 8'hFF);    // left shift with wrap offset
    add_map(15, 1, 8'd7, 8'd0, 8'hF0, 8'hFC, 8'd1);    // right shift
    add_map(15, 2, 8'd8, 8'd1, 8'hFF, 8'd0, 8'd5);     // bad source byte
    add_map(15, 3, 8'd1, 8'd200, 8'hFF, 8'd0, 8'd5);   // bad destination byte
    add_map(15, 4, 8'd2, 8'd2, 8'hFF, 8'd8, 8'd0);     // large left shift
    add_map(15, 5, 8'd3, 8'd3, 8'hFF, 8'h80, 8'd0);    // large right shift
    add_map(15, 6, 8'd4, 8'd2, 8'hAA, 8'hFF, 8'd0);    // OR into same byte
    add_map(15, 7, 8'd5, 8'd5, 8'h00, 8'd7, 8'h80);
    add_frame(0, 1);
    add_frame(15, 1);
    tmp = rand_cmd(FUNC_SPARE); pending_cmds.push_back(tmp);
    tmp = rand_cmd(FUNC_SPARE_B); pending_cmds.push_back(tmp);
    tmp = rand_cmd(FUNC_SPARE_C); pending_cmds.push_back(tmp);
    add_frame(0, 1);
    add_rule(7, 2'd0, 32'h0, 32'h0, 0);                // disabled rule
    add_frame(7, 1);
    tmp = rand_cmd(FUNC_CLEAR); tmp.drain_first = 1; pending_cmds.push_back(tmp);
    for (int k = 0; k < NSLOT; k++) gen_mask[k] = 0;
    add_frame(0, 1);

    // random part
    for (int i = 0; i < 460; i++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, NSLOT - 1);
      if (pick < 12) begin
        case ($urandom_range(0, 3))
          0: add_rule(s, 2'($urandom), $urandom, 32'h0, $urandom_range(0, 4) != 0);
          1: add_rule(s, 2'($urandom), $urandom, 32'hFFFF_FFFF, $urandom_range(0, 4) != 0);
          2: add_rule(s, 2'($urandom), $urandom, 32'hFFFF_F000, $urandom_range(0, 4) != 0);
          default: add_rule(s, 2'($urandom), $urandom, $urandom, 1'($urandom));
        endcase
      end else if (pick < 22) begin
        add_action(s, 2'($urandom), ($urandom_range(0, 2) == 0) ? PassthroughId : $urandom,
                   ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom),
                   ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15)));
      end else if (pick < 36) begin
        add_map(s, $urandom_range(0, NMAP - 1),
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                8'($urandom),
                ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20) - 10),
                8'($urandom));
      end else if (pick < 37) begin
        tmp = rand_cmd(FUNC_CLEAR); pending_cmds.push_back(tmp);
        for (int k = 0; k < NSLOT; k++) gen_mask[k] = 0;
      end else if (pick < 39) begin
        tmp = rand_cmd(3'($urandom_range(5, 7))); pending_cmds.push_back(tmp);
      end else begin
        add_frame(s, $urandom_range(0, 9) < 8);
      end
      if (i % 120 == 60) pending_cmds[pending_cmds.size()-1].drain_first = 1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_tvalid && expected_routes.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_routes.size() == 0) begin
      $display("frame_routing_rule_engine: match");
    end else begin
      $display("frame_routing_rule_engine: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/frre_pkg.sv
hw/rtl/frre_cell.sv
hw/rtl/frame_routing_rule_engine.sv
test/tb_top.sv
